### hw/rtl/chip8_instruction_core_assert.svh
// assertion macros for the chip8 instruction core
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// condition must never hold outside reset
`define C8_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("c8core: forbidden condition seen");

// antecedent in one cycle implies consequent in the next
`define C8_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c8core: expected follow-up missing");

`endif

### hw/rtl/c8core_pkg.sv
// shared constants, types and font table of the chip8 instruction core
`timescale 1ns / 1ps

package c8core_pkg;

   localparam int MEMORY_BYTES  = 4096;
   localparam int ADDR_W        = $clog2(MEMORY_BYTES);
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
   localparam int PIX_W         = COL_W + ROW_W;
   localparam int STACK_DEPTH   = 16;
   localparam int SP_W          = $clog2(STACK_DEPTH);
   localparam int FONT_BYTES    = 80;
   localparam int FONT_W        = $clog2(FONT_BYTES);

   localparam logic [ADDR_W-1:0] PC_RESET = ADDR_W'(12'h200);

   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_KEY   = 3'd1;
   localparam logic [2:0] CMD_EXEC  = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_PIXEL = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [7:0] KK_SKP   = 8'h9E;
   localparam logic [7:0] KK_SKNP  = 8'hA1;
   localparam logic [7:0] KK_LDDT  = 8'h07;
   localparam logic [7:0] KK_LDK   = 8'h0A;
   localparam logic [7:0] KK_SETDT = 8'h15;
   localparam logic [7:0] KK_SETST = 8'h18;
   localparam logic [7:0] KK_ADDI  = 8'h1E;
   localparam logic [7:0] KK_FONT  = 8'h29;
   localparam logic [7:0] KK_BCD   = 8'h33;
   localparam logic [7:0] KK_STORE = 8'h55;
   localparam logic [7:0] KK_LOAD  = 8'h65;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic                    we;
      logic [ROW_W-1:0]        row;
      logic [SCREEN_WIDTH-1:0] wdata;
   } fb_req_type;

   typedef struct packed {
      logic       we;
      logic [3:0] waddr;
      logic [7:0] wdata;
      logic [3:0] raddr;
   } vreg_req_type;

   typedef struct packed {
      logic mem_busy;
      logic fb_busy;
   } init_status_type;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
   };

   function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
      logic [7:0] r;
      r = 8'h00;
      if (a < ADDR_W'(FONT_BYTES)) begin
         r = FONT_ROM[a[FONT_W-1:0]];
      end
      return r;
   endfunction

endpackage

### hw/rtl/c8core_req_if.sv
// command channel carrying one request word
`timescale 1ns / 1ps

interface c8core_req_if import c8core_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        command;
   logic [ADDR_W-1:0] address;
   logic [7:0]        data;
   logic [3:0]        key_index;
   logic              key_pressed;
   logic [7:0]        random_byte;
   logic [PIX_W-1:0]  pixel_index;

   modport source (output valid, command, address, data, key_index, key_pressed,
                   random_byte, pixel_index, input ready);
   modport sink (input valid, command, address, data, key_index, key_pressed,
                 random_byte, pixel_index, output ready);
endinterface

### hw/rtl/c8core_rsp_if.sv
// result channel carrying one response word
`timescale 1ns / 1ps

interface c8core_rsp_if import c8core_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] program_counter;
   logic [15:0]       opcode;
   logic              display_changed;
   logic              waiting_for_key;
   logic              sound_active;
   logic              pixel;
   logic [7:0]        memory_byte;
   logic              unknown_opcode;

   modport source (output valid, program_counter, opcode, display_changed,
                   waiting_for_key, sound_active, pixel, memory_byte, unknown_opcode,
                   input ready);
   modport sink (input valid, program_counter, opcode, display_changed,
                 waiting_for_key, sound_active, pixel, memory_byte, unknown_opcode,
                 output ready);
endinterface

### hw/rtl/c8core_mainmem.sv
// 4 KiB main memory with font preload sweep after reset
`timescale 1ns / 1ps

module c8core_mainmem import c8core_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  mem_rdata,
   output logic        mem_busy
);

   logic [7:0]      mem_array [MEMORY_BYTES];
   logic [ADDR_W:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]      rdata_ff;

   assign mem_busy   = ~clr_cnt_ff[ADDR_W];
   assign clr_cnt_in = mem_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign mem_rdata  = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // preload sweep writes font bytes low, zeros above
   always_ff @(posedge clock) begin
      if (mem_busy) begin
         mem_array[clr_cnt_ff[ADDR_W-1:0]] <= font_byte(clr_cnt_ff[ADDR_W-1:0]);
      end else if (mem_req.we) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem_array[mem_req.addr];
   end

endmodule

### hw/rtl/c8core_fbuf.sv
// framebuffer stored as one 64-bit word per screen row
`timescale 1ns / 1ps

module c8core_fbuf import c8core_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  fb_req_type              fb_req,
   output logic [SCREEN_WIDTH-1:0] fb_rdata,
   output logic                    fb_busy
);

   logic [SCREEN_WIDTH-1:0] row_array [SCREEN_HEIGHT];
   logic [ROW_W:0]          clr_cnt_ff, clr_cnt_in;
   logic [SCREEN_WIDTH-1:0] rdata_ff;

   assign fb_busy    = ~clr_cnt_ff[ROW_W];
   assign clr_cnt_in = fb_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign fb_rdata   = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fb_busy) begin
         row_array[clr_cnt_ff[ROW_W-1:0]] <= '0;
      end else if (fb_req.we) begin
         row_array[fb_req.row] <= fb_req.wdata;
      end
      rdata_ff <= row_array[fb_req.row];
   end

endmodule

### hw/rtl/c8core_vregs.sv
// V0-VF register file, one read and one write port, zero until written
`timescale 1ns / 1ps

module c8core_vregs import c8core_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  vreg_req_type vreg_req,
   output logic [7:0]   vreg_rdata
);

   logic [7:0]  reg_array [16];
   logic [15:0] valid_ff;
   logic [7:0]  rdata_ff;

   assign vreg_rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (vreg_req.we) begin
         valid_ff[vreg_req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (vreg_req.we) begin
         reg_array[vreg_req.waddr] <= vreg_req.wdata;
      end
      rdata_ff <= valid_ff[vreg_req.raddr] ? reg_array[vreg_req.raddr] : 8'h00;
   end

endmodule

### hw/rtl/c8core_seq.sv
// instruction sequencer: fetch, decode, execute and memory walks
`timescale 1ns / 1ps

module c8core_seq import c8core_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   c8core_req_if.sink              req_chan,
   c8core_rsp_if.source            rsp_chan,
   input  init_status_type         init_status,
   output mem_req_type             mem_req,
   input  logic [7:0]              mem_rdata,
   output fb_req_type              fb_req,
   input  logic [SCREEN_WIDTH-1:0] fb_rdata,
   output vreg_req_type            vreg_req,
   input  logic [7:0]              vreg_rdata
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_CMD    = 5'd1;
   localparam logic [4:0] ST_CAP    = 5'd2;
   localparam logic [4:0] ST_FETCH1 = 5'd3;
   localparam logic [4:0] ST_FETCH2 = 5'd4;
   localparam logic [4:0] ST_LATX   = 5'd5;
   localparam logic [4:0] ST_LATY   = 5'd6;
   localparam logic [4:0] ST_EXEC   = 5'd7;
   localparam logic [4:0] ST_WRF    = 5'd8;
   localparam logic [4:0] ST_CLR    = 5'd9;
   localparam logic [4:0] ST_DRD    = 5'd10;
   localparam logic [4:0] ST_DWR    = 5'd11;
   localparam logic [4:0] ST_BCD    = 5'd12;
   localparam logic [4:0] ST_SRD    = 5'd13;
   localparam logic [4:0] ST_SWR    = 5'd14;
   localparam logic [4:0] ST_LRD    = 5'd15;
   localparam logic [4:0] ST_LWR    = 5'd16;
   localparam logic [4:0] ST_DONE   = 5'd17;

   logic [4:0]              state_ff, state_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [7:0]              data_ff, data_in;
   logic [3:0]              key_idx_ff, key_idx_in;
   logic                    key_prs_ff, key_prs_in;
   logic [7:0]              rnd_ff, rnd_in;
   logic [PIX_W-1:0]        pix_idx_ff, pix_idx_in;
   logic [ADDR_W-1:0]       pc_ff, pc_in;
   logic [15:0]             i_ff, i_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   logic [ADDR_W-1:0]       stack_ff [STACK_DEPTH];
   logic [ADDR_W-1:0]       stack_in [STACK_DEPTH];
   logic [7:0]              delay_ff, delay_in;
   logic [7:0]              sound_ff, sound_in;
   logic [15:0]             keys_ff, keys_in;
   logic [7:0]              hi_ff, hi_in;
   logic [15:0]             op_ff, op_in;
   logic [7:0]              vx_ff, vx_in;
   logic [7:0]              vy_ff, vy_in;
   logic [ROW_W-1:0]        cnt_ff, cnt_in;
   logic                    flag_ff, flag_in;
   logic                    hit_ff, hit_in;
   logic [COL_W-1:0]        x0_ff, x0_in;
   logic [ROW_W-1:0]        y0_ff, y0_in;
   logic [3:0]              bcd_ff [3];
   logic [3:0]              bcd_in [3];
   logic                    drew_ff, drew_in;
   logic                    wait_ff, wait_in;
   logic                    unk_ff, unk_in;
   logic                    pix_ff, pix_in;
   logic [7:0]              mbyte_ff, mbyte_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_pc_ff, rsp_pc_in;
   logic [15:0]             rsp_op_ff, rsp_op_in;
   logic                    rsp_drew_ff, rsp_drew_in;
   logic                    rsp_wait_ff, rsp_wait_in;
   logic                    rsp_sound_ff, rsp_sound_in;
   logic                    rsp_pix_ff, rsp_pix_in;
   logic [7:0]              rsp_mbyte_ff, rsp_mbyte_in;
   logic                    rsp_unk_ff, rsp_unk_in;

   logic                    req_ready;
   logic [3:0]              op_x, op_n;
   logic [7:0]              op_kk;
   logic [ADDR_W-1:0]       op_nnn;
   logic [ADDR_W-1:0]       pc_plus2, pc_plus4;
   logic [SP_W-1:0]         sp_inc, sp_dec;
   logic [8:0]              sum9;
   logic [3:0]              key_hi;
   logic [1:0]              hund;
   logic [7:0]              rem100;
   logic [14:0]             tens_prod;
   logic [3:0]              tens;
   logic [7:0]              sprite_rev;
   logic [SCREEN_WIDTH-1:0] sprite_wide, sprite_rot;
   logic                    hit_now;
   logic [ADDR_W-1:0]       i_walk;

   assign req_ready      = (state_ff == ST_IDLE) && !init_status.mem_busy
                           && !init_status.fb_busy;
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.program_counter = rsp_pc_ff;
   assign rsp_chan.opcode          = rsp_op_ff;
   assign rsp_chan.display_changed = rsp_drew_ff;
   assign rsp_chan.waiting_for_key = rsp_wait_ff;
   assign rsp_chan.sound_active    = rsp_sound_ff;
   assign rsp_chan.pixel           = rsp_pix_ff;
   assign rsp_chan.memory_byte     = rsp_mbyte_ff;
   assign rsp_chan.unknown_opcode  = rsp_unk_ff;

   assign op_x   = op_ff[11:8];
   assign op_n   = op_ff[3:0];
   assign op_kk  = op_ff[7:0];
   assign op_nnn = op_ff[ADDR_W-1:0];

   assign pc_plus2 = pc_ff + ADDR_W'(2);
   assign pc_plus4 = pc_ff + ADDR_W'(4);
   assign sp_inc   = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_dec   = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign sum9     = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign i_walk   = i_ff[ADDR_W-1:0] + ADDR_W'(cnt_ff);

   // decimal digits: compare for hundreds, reciprocal multiply for tens
   assign hund      = (vx_ff >= 8'd200) ? 2'd2 : (vx_ff >= 8'd100) ? 2'd1 : 2'd0;
   assign rem100    = vx_ff - 8'(hund * 7'd100);
   assign tens_prod = rem100[6:0] * 8'd205;
   assign tens      = tens_prod[14:11];

   // sprite byte msb lands on column x0, wrapping around the row
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         sprite_rev[b] = mem_rdata[7 - b];
      end
   end
   assign sprite_wide = {{(SCREEN_WIDTH - 8){1'b0}}, sprite_rev};
   assign sprite_rot  = (sprite_wide << x0_ff)
                        | (sprite_wide >> (7'(SCREEN_WIDTH) - {1'b0, x0_ff}));
   assign hit_now     = |(sprite_rot & fb_rdata);

   // highest pressed key wins
   always_comb begin
      key_hi = 4'h0;
      for (int k = 0; k < 16; k++) begin
         if (keys_ff[k]) begin
            key_hi = 4'(k);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      key_idx_in = key_idx_ff;
      key_prs_in = key_prs_ff;
      rnd_in     = rnd_ff;
      pix_idx_in = pix_idx_ff;
      pc_in      = pc_ff;
      i_in       = i_ff;
      sp_in      = sp_ff;
      stack_in   = stack_ff;
      delay_in   = delay_ff;
      sound_in   = sound_ff;
      keys_in    = keys_ff;
      hi_in      = hi_ff;
      op_in      = op_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      cnt_in     = cnt_ff;
      flag_in    = flag_ff;
      hit_in     = hit_ff;
      x0_in      = x0_ff;
      y0_in      = y0_ff;
      bcd_in     = bcd_ff;
      drew_in    = drew_ff;
      wait_in    = wait_ff;
      unk_in     = unk_ff;
      pix_in     = pix_ff;
      mbyte_in   = mbyte_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pc_in    = rsp_pc_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_drew_in  = rsp_drew_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_sound_in = rsp_sound_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_mbyte_in = rsp_mbyte_ff;
      rsp_unk_in   = rsp_unk_ff;

      mem_req  = '0;
      fb_req   = '0;
      vreg_req = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && req_ready) begin
               cmd_in     = req_chan.command;
               addr_in    = req_chan.address;
               data_in    = req_chan.data;
               key_idx_in = req_chan.key_index;
               key_prs_in = req_chan.key_pressed;
               rnd_in     = req_chan.random_byte;
               pix_idx_in = req_chan.pixel_index;
               drew_in    = 1'b0;
               wait_in    = 1'b0;
               unk_in     = 1'b0;
               pix_in     = 1'b0;
               mbyte_in   = 8'h00;
               state_in   = ST_CMD;
            end
         end
         ST_CMD: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_LOAD: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = addr_ff;
                  mem_req.wdata = data_ff;
               end
               CMD_KEY: begin
                  keys_in[key_idx_ff] = key_prs_ff;
               end
               CMD_EXEC: begin
                  mem_req.addr = pc_ff;
                  state_in     = ST_FETCH1;
               end
               CMD_TICK: begin
                  if (delay_ff != 8'h00) delay_in = delay_ff - 1'b1;
                  if (sound_ff != 8'h00) sound_in = sound_ff - 1'b1;
               end
               CMD_PIXEL: begin
                  fb_req.row = pix_idx_ff[PIX_W-1:COL_W];
                  state_in   = ST_CAP;
               end
               CMD_READ: begin
                  mem_req.addr = addr_ff;
                  state_in     = ST_CAP;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CAP: begin
            if (cmd_ff == CMD_PIXEL) begin
               pix_in = fb_rdata[pix_idx_ff[COL_W-1:0]];
            end else begin
               mbyte_in = mem_rdata;
            end
            state_in = ST_DONE;
         end
         ST_FETCH1: begin
            hi_in        = mem_rdata;
            mem_req.addr = pc_ff + 1'b1;
            state_in     = ST_FETCH2;
         end
         ST_FETCH2: begin
            op_in = {hi_ff, mem_rdata};
            // Bnnn needs V0 in place of Vx
            vreg_req.raddr = (hi_ff[7:4] == 4'hB) ? 4'h0 : hi_ff[3:0];
            state_in       = ST_LATX;
         end
         ST_LATX: begin
            vx_in          = vreg_rdata;
            vreg_req.raddr = op_ff[7:4];
            state_in       = ST_LATY;
         end
         ST_LATY: begin
            vy_in    = vreg_rdata;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in       = ST_DONE;
            pc_in          = pc_plus2;
            vreg_req.waddr = op_x;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == OP_CLS) begin
                     drew_in  = 1'b1;
                     cnt_in   = '0;
                     state_in = ST_CLR;
                  end else if (op_ff == OP_RET) begin
                     sp_in = sp_dec;
                     pc_in = stack_ff[sp_dec] + ADDR_W'(2);
                  end else begin
                     unk_in = 1'b1;
                  end
               end
               4'h1: pc_in = op_nnn;
               4'h2: begin
                  stack_in[sp_ff] = pc_ff;
                  sp_in           = sp_inc;
                  pc_in           = op_nnn;
               end
               4'h3: if (vx_ff == op_kk) pc_in = pc_plus4;
               4'h4: if (vx_ff != op_kk) pc_in = pc_plus4;
               4'h5: begin
                  if (op_n != 4'h0) unk_in = 1'b1;
                  else if (vx_ff == vy_ff) pc_in = pc_plus4;
               end
               4'h6: begin
                  vreg_req.we    = 1'b1;
                  vreg_req.wdata = op_kk;
               end
               4'h7: begin
                  vreg_req.we    = 1'b1;
                  vreg_req.wdata = vx_ff + op_kk;
               end
               4'h8: begin
                  vreg_req.we = 1'b1;
                  case (op_n)
                     4'h0: vreg_req.wdata = vy_ff;
                     4'h1: vreg_req.wdata = vx_ff | vy_ff;
                     4'h2: vreg_req.wdata = vx_ff & vy_ff;
                     4'h3: vreg_req.wdata = vx_ff ^ vy_ff;
                     4'h4: begin
                        vreg_req.wdata = sum9[7:0];
                        flag_in        = sum9[8];
                        state_in       = ST_WRF;
                     end
                     4'h5: begin
                        vreg_req.wdata = vx_ff - vy_ff;
                        flag_in        = (vx_ff >= vy_ff);
                        state_in       = ST_WRF;
                     end
                     4'h6: begin
                        vreg_req.wdata = {1'b0, vx_ff[7:1]};
                        flag_in        = vx_ff[0];
                        state_in       = ST_WRF;
                     end
                     4'h7: begin
                        vreg_req.wdata = vy_ff - vx_ff;
                        flag_in        = (vy_ff >= vx_ff);
                        state_in       = ST_WRF;
                     end
                     4'hE: begin
                        vreg_req.wdata = {vx_ff[6:0], 1'b0};
                        flag_in        = vx_ff[7];
                        state_in       = ST_WRF;
                     end
                     default: begin
                        vreg_req.we = 1'b0;
                        unk_in      = 1'b1;
                     end
                  endcase
               end
               4'h9: begin
                  if (op_n != 4'h0) unk_in = 1'b1;
                  else if (vx_ff != vy_ff) pc_in = pc_plus4;
               end
               4'hA: i_in = 16'(op_nnn);
               4'hB: pc_in = ADDR_W'(vx_ff) + op_nnn;
               4'hC: begin
                  vreg_req.we    = 1'b1;
                  vreg_req.wdata = rnd_ff & op_kk;
               end
               4'hD: begin
                  x0_in   = vx_ff[COL_W-1:0];
                  y0_in   = vy_ff[ROW_W-1:0];
                  cnt_in  = '0;
                  hit_in  = 1'b0;
                  flag_in = 1'b0;
                  if (op_n == 4'h0) begin
                     state_in = ST_WRF;
                  end else begin
                     drew_in  = 1'b1;
                     state_in = ST_DRD;
                  end
               end
               4'hE: begin
                  if (op_kk == KK_SKP) begin
                     if (keys_ff[vx_ff[3:0]]) pc_in = pc_plus4;
                  end else if (op_kk == KK_SKNP) begin
                     if (!keys_ff[vx_ff[3:0]]) pc_in = pc_plus4;
                  end else begin
                     unk_in = 1'b1;
                  end
               end
               default: begin
                  case (op_kk)
                     KK_LDDT: begin
                        vreg_req.we    = 1'b1;
                        vreg_req.wdata = delay_ff;
                     end
                     KK_LDK: begin
                        if (keys_ff != 16'h0000) begin
                           vreg_req.we    = 1'b1;
                           vreg_req.wdata = {4'h0, key_hi};
                        end else begin
                           wait_in = 1'b1;
                           pc_in   = pc_ff;
                        end
                     end
                     KK_SETDT: delay_in = vx_ff;
                     KK_SETST: sound_in = vx_ff;
                     KK_ADDI:  i_in = i_ff + 16'(vx_ff);
                     KK_FONT:  i_in = 16'({vx_ff[3:0], 2'b00}) + 16'(vx_ff[3:0]);
                     KK_BCD: begin
                        bcd_in[0] = {2'b00, hund};
                        bcd_in[1] = tens;
                        bcd_in[2] = 4'(rem100 - 8'({tens, 3'b000}) - 8'({tens, 1'b0}));
                        cnt_in    = '0;
                        state_in  = ST_BCD;
                     end
                     KK_STORE: begin
                        cnt_in   = '0;
                        state_in = ST_SRD;
                     end
                     KK_LOAD: begin
                        cnt_in   = '0;
                        state_in = ST_LRD;
                     end
                     default: unk_in = 1'b1;
                  endcase
               end
            endcase
         end
         ST_WRF: begin
            vreg_req.we    = 1'b1;
            vreg_req.waddr = 4'hF;
            vreg_req.wdata = {7'b0, flag_ff};
            state_in       = ST_DONE;
         end
         ST_CLR: begin
            fb_req.we  = 1'b1;
            fb_req.row = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == ROW_W'(SCREEN_HEIGHT - 1)) state_in = ST_DONE;
         end
         ST_DRD: begin
            mem_req.addr = i_walk;
            fb_req.row   = y0_ff + cnt_ff;
            state_in     = ST_DWR;
         end
         ST_DWR: begin
            fb_req.we    = 1'b1;
            fb_req.row   = y0_ff + cnt_ff;
            fb_req.wdata = fb_rdata ^ sprite_rot;
            hit_in       = hit_ff | hit_now;
            cnt_in       = cnt_ff + 1'b1;
            if ((cnt_ff + 1'b1) == ROW_W'(op_n)) begin
               flag_in  = hit_ff | hit_now;
               state_in = ST_WRF;
            end else begin
               state_in = ST_DRD;
            end
         end
         ST_BCD: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = i_walk;
            mem_req.wdata = {4'h0, bcd_ff[cnt_ff[1:0]]};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ROW_W'(2)) state_in = ST_DONE;
         end
         ST_SRD: begin
            vreg_req.raddr = cnt_ff[3:0];
            state_in       = ST_SWR;
         end
         ST_SWR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = i_walk;
            mem_req.wdata = vreg_rdata;
            cnt_in        = cnt_ff + 1'b1;
            state_in      = (cnt_ff[3:0] == op_x) ? ST_DONE : ST_SRD;
         end
         ST_LRD: begin
            mem_req.addr = i_walk;
            state_in     = ST_LWR;
         end
         ST_LWR: begin
            vreg_req.we    = 1'b1;
            vreg_req.waddr = cnt_ff[3:0];
            vreg_req.wdata = mem_rdata;
            cnt_in         = cnt_ff + 1'b1;
            state_in       = (cnt_ff[3:0] == op_x) ? ST_DONE : ST_LRD;
         end
         ST_DONE: begin
            // result register frees when empty or taken this cycle
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = pc_ff;
               rsp_op_in    = (cmd_ff == CMD_EXEC) ? op_ff : 16'h0000;
               rsp_drew_in  = drew_ff;
               rsp_wait_in  = wait_ff;
               rsp_sound_in = (sound_ff != 8'h00);
               rsp_pix_in   = pix_ff;
               rsp_mbyte_in = mbyte_ff;
               rsp_unk_in   = unk_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_RESET;
         i_ff         <= '0;
         sp_ff        <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
         keys_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < STACK_DEPTH; s++) begin
            stack_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         sp_ff        <= sp_in;
         delay_ff     <= delay_in;
         sound_ff     <= sound_in;
         keys_ff      <= keys_in;
         rsp_valid_ff <= rsp_valid_in;
         stack_ff     <= stack_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
      key_idx_ff   <= key_idx_in;
      key_prs_ff   <= key_prs_in;
      rnd_ff       <= rnd_in;
      pix_idx_ff   <= pix_idx_in;
      hi_ff        <= hi_in;
      op_ff        <= op_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      cnt_ff       <= cnt_in;
      flag_ff      <= flag_in;
      hit_ff       <= hit_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      bcd_ff       <= bcd_in;
      drew_ff      <= drew_in;
      wait_ff      <= wait_in;
      unk_ff       <= unk_in;
      pix_ff       <= pix_in;
      mbyte_ff     <= mbyte_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_drew_ff  <= rsp_drew_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_sound_ff <= rsp_sound_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_mbyte_ff <= rsp_mbyte_in;
      rsp_unk_ff   <= rsp_unk_in;
   end

endmodule

### hw/rtl/chip8_instruction_core.sv
// CHIP-8 interpreter core. Each request word carries one command and gets one
// response word. After reset the core preloads main memory (font at 0-79, zeros
// above) and clears the framebuffer alongside; no request is taken during that
// sweep. One command is handled at a time. Pixel and memory reads add a capture
// step; a plain instruction does two fetch reads from the single main-memory
// port, two reads from the one-read-port register file, execute and respond. A
// flag-writing ALU op adds a VF write, a draw a read and a write per sprite row
// plus a VF write, a clear writes all 32 framebuffer rows (one row per cycle),
// BCD writes three digits, Fx55/Fx65 a read and a write per register moved. A
// finished response waits in an output register as the next request is taken.
`timescale 1ns / 1ps
`include "chip8_instruction_core_assert.svh"

module chip8_instruction_core import c8core_pkg::*; (
   input logic          clock,
   input logic          reset,
   c8core_req_if.sink   req_chan,
   c8core_rsp_if.source rsp_chan
);

   mem_req_type             mem_req;
   logic [7:0]              mem_rdata;
   logic                    mem_busy;
   fb_req_type              fb_req;
   logic [SCREEN_WIDTH-1:0] fb_rdata;
   logic                    fb_busy;
   vreg_req_type            vreg_req;
   logic [7:0]              vreg_rdata;
   init_status_type         init_status;

   assign init_status.mem_busy = mem_busy;
   assign init_status.fb_busy  = fb_busy;

   c8core_mainmem u_mainmem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .mem_busy  (mem_busy)
   );

   c8core_fbuf u_fbuf (
      .clock    (clock),
      .reset    (reset),
      .fb_req   (fb_req),
      .fb_rdata (fb_rdata),
      .fb_busy  (fb_busy)
   );

   c8core_vregs u_vregs (
      .clock      (clock),
      .reset      (reset),
      .vreg_req   (vreg_req),
      .vreg_rdata (vreg_rdata)
   );

   c8core_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .init_status (init_status),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata),
      .fb_req      (fb_req),
      .fb_rdata    (fb_rdata),
      .vreg_req    (vreg_req),
      .vreg_rdata  (vreg_rdata)
   );

   `C8_ASSERT_NEVER(a_no_accept_in_init, req_chan.valid && req_chan.ready && (mem_busy || fb_busy))
   `C8_ASSERT_NEXT(a_one_word_at_a_time, req_chan.valid && req_chan.ready, !req_chan.ready)
   `C8_ASSERT_NEVER(a_no_mem_write_in_init, mem_req.we && mem_busy)
   `C8_ASSERT_NEVER(a_no_fb_write_in_init, fb_req.we && fb_busy)

endmodule

### tb/chip8_instruction_core_checker.sv
// watches both channels of the chip8 core, predicts each response word and compares
`timescale 1ns / 1ps

module chip8_instruction_core_checker import c8core_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   c8core_req_if             req_mon,
   c8core_rsp_if             rsp_mon,
   output int                mismatch_count,
   output int                outstanding,
   output logic [ADDR_W-1:0] model_pc
);

   typedef struct {
      logic [ADDR_W-1:0] program_counter;
      logic [15:0]       opcode;
      logic              display_changed;
      logic              waiting_for_key;
      logic              sound_active;
      logic              pixel;
      logic [7:0]        memory_byte;
      logic              unknown_opcode;
   } core_rsp_type;

   core_rsp_type      rsp_expected_q[$];

   logic [7:0]        main_mem [MEMORY_BYTES];
   logic              screen [SCREEN_WIDTH*SCREEN_HEIGHT];
   logic [7:0]        vreg [16];
   logic [15:0]       idx_reg;
   logic [ADDR_W-1:0] pc_reg;
   logic [ADDR_W-1:0] call_stack [STACK_DEPTH];
   logic [SP_W-1:0]   sp_reg;
   logic [7:0]        delay_tmr;
   logic [7:0]        sound_tmr;
   logic [15:0]       keys_down;

   assign model_pc = pc_reg;

   task automatic clear_state();
      for (int a = 0; a < MEMORY_BYTES; a++) main_mem[a] = 8'h00;
      for (int a = 0; a < FONT_BYTES; a++) main_mem[a] = FONT_ROM[a];
      for (int a = 0; a < SCREEN_WIDTH*SCREEN_HEIGHT; a++) screen[a] = 1'b0;
      for (int a = 0; a < 16; a++) vreg[a] = 8'h00;
      for (int a = 0; a < STACK_DEPTH; a++) call_stack[a] = '0;
      idx_reg   = 16'h0000;
      pc_reg    = PC_RESET;
      sp_reg    = '0;
      delay_tmr = 8'h00;
      sound_tmr = 8'h00;
      keys_down = 16'h0000;
   endtask

   task automatic execute_instr(input logic [7:0] rnd, inout core_rsp_type r);
      logic [15:0]       op;
      logic [3:0]        x, y, n;
      logic [7:0]        kk, a, b;
      logic [ADDR_W-1:0] nnn, nxt, ia;
      logic [8:0]        sum;
      logic              flag, hit, bitv;
      logic [5:0]        x0, px;
      logic [4:0]        y0, py;
      logic [7:0]        row;
      int                pos;
      op  = {main_mem[pc_reg], main_mem[pc_reg + 12'd1]};
      x   = op[11:8];
      y   = op[7:4];
      n   = op[3:0];
      kk  = op[7:0];
      nnn = op[11:0];
      nxt = pc_reg + 12'd2;
      a   = vreg[x];
      b   = vreg[y];
      case (op[15:12])
         4'h0: begin
            if (op == OP_CLS) begin
               for (int k = 0; k < SCREEN_WIDTH*SCREEN_HEIGHT; k++) screen[k] = 1'b0;
               r.display_changed = 1'b1;
            end else if (op == OP_RET) begin
               sp_reg = sp_reg - 1'b1;
               nxt = call_stack[sp_reg] + 12'd2;
            end else begin
               r.unknown_opcode = 1'b1;
            end
         end
         4'h1: nxt = nnn;
         4'h2: begin
            call_stack[sp_reg] = pc_reg;
            sp_reg = sp_reg + 1'b1;
            nxt = nnn;
         end
         4'h3: if (a == kk) nxt = nxt + 12'd2;
         4'h4: if (a != kk) nxt = nxt + 12'd2;
         4'h5: begin
            if (n != 4'h0) r.unknown_opcode = 1'b1;
            else if (a == b) nxt = nxt + 12'd2;
         end
         4'h6: vreg[x] = kk;
         4'h7: vreg[x] = a + kk;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = b;
               4'h1: vreg[x] = a | b;
               4'h2: vreg[x] = a & b;
               4'h3: vreg[x] = a ^ b;
               4'h4: begin
                  sum = {1'b0, a} + {1'b0, b};
                  vreg[x] = sum[7:0];
                  vreg[15] = {7'd0, sum[8]};
               end
               4'h5: begin
                  flag = a >= b;
                  vreg[x] = a - b;
                  vreg[15] = {7'd0, flag};
               end
               4'h6: begin
                  vreg[x] = a >> 1;
                  vreg[15] = {7'd0, a[0]};
               end
               4'h7: begin
                  flag = b >= a;
                  vreg[x] = b - a;
                  vreg[15] = {7'd0, flag};
               end
               4'hE: begin
                  vreg[x] = a << 1;
                  vreg[15] = {7'd0, a[7]};
               end
               default: r.unknown_opcode = 1'b1;
            endcase
         end
         4'h9: begin
            if (n != 4'h0) r.unknown_opcode = 1'b1;
            else if (a != b) nxt = nxt + 12'd2;
         end
         4'hA: idx_reg = {4'h0, nnn};
         4'hB: nxt = {4'h0, vreg[0]} + nnn;
         4'hC: vreg[x] = rnd & kk;
         4'hD: begin
            x0  = a[5:0];
            y0  = b[4:0];
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
               ia  = idx_reg[11:0] + ADDR_W'(i);
               row = main_mem[ia];
               for (int j = 0; j < 8; j++) begin
                  bitv = row[7-j];
                  px   = x0 + 6'(j);
                  py   = y0 + 5'(i);
                  pos  = {py, px};
                  if (bitv && screen[pos]) hit = 1'b1;
                  screen[pos] = screen[pos] ^ bitv;
               end
            end
            vreg[15] = {7'd0, hit};
            r.display_changed = n != 4'h0;
         end
         4'hE: begin
            if (kk == KK_SKP) begin
               if (keys_down[a[3:0]]) nxt = nxt + 12'd2;
            end else if (kk == KK_SKNP) begin
               if (!keys_down[a[3:0]]) nxt = nxt + 12'd2;
            end else begin
               r.unknown_opcode = 1'b1;
            end
         end
         default: begin
            case (kk)
               KK_LDDT: vreg[x] = delay_tmr;
               KK_LDK: begin
                  flag = 1'b0;
                  for (int i = 0; i < 16; i++) begin
                     if (keys_down[i]) begin
                        vreg[x] = 8'(i);
                        flag = 1'b1;
                     end
                  end
                  if (!flag) begin
                     r.waiting_for_key = 1'b1;
                     nxt = pc_reg;
                  end
               end
               KK_SETDT: delay_tmr = a;
               KK_SETST: sound_tmr = a;
               KK_ADDI:  idx_reg = idx_reg + {8'h00, a};
               KK_FONT:  idx_reg = 16'({a[3:0]} * 5);
               KK_BCD: begin
                  main_mem[idx_reg[11:0]]         = a / 100;
                  main_mem[idx_reg[11:0] + 12'd1] = (a / 10) % 10;
                  main_mem[idx_reg[11:0] + 12'd2] = a % 10;
               end
               KK_STORE: begin
                  for (int i = 0; i <= x; i++)
                     main_mem[idx_reg[11:0] + ADDR_W'(i)] = vreg[i];
               end
               KK_LOAD: begin
                  for (int i = 0; i <= x; i++)
                     vreg[i] = main_mem[idx_reg[11:0] + ADDR_W'(i)];
               end
               default: r.unknown_opcode = 1'b1;
            endcase
         end
      endcase
      pc_reg   = nxt;
      r.opcode = op;
   endtask

   task automatic predict_rsp();
      core_rsp_type r;
      r = '{default: '0};
      case (req_mon.command)
         CMD_LOAD: main_mem[req_mon.address] = req_mon.data;
         CMD_KEY:  keys_down[req_mon.key_index] = req_mon.key_pressed;
         CMD_EXEC: execute_instr(req_mon.random_byte, r);
         CMD_TICK: begin
            if (delay_tmr != 8'h00) delay_tmr = delay_tmr - 8'd1;
            if (sound_tmr != 8'h00) sound_tmr = sound_tmr - 8'd1;
         end
         CMD_PIXEL: r.pixel = screen[req_mon.pixel_index];
         CMD_READ:  r.memory_byte = main_mem[req_mon.address];
         default: ;
      endcase
      r.program_counter = pc_reg;
      r.sound_active    = sound_tmr != 8'h00;
      rsp_expected_q.push_back(r);
   endtask

   function automatic int field_differs(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   task automatic compare_rsp();
      core_rsp_type e;
      int           bad;
      if (rsp_expected_q.size() == 0) begin
         $error("response word with nothing expected");
         mismatch_count++;
         return;
      end
      e   = rsp_expected_q.pop_front();
      bad = 0;
      bad += field_differs("program_counter", e.program_counter, rsp_mon.program_counter);
      bad += field_differs("opcode", e.opcode, rsp_mon.opcode);
      bad += field_differs("display_changed", e.display_changed, rsp_mon.display_changed);
      bad += field_differs("waiting_for_key", e.waiting_for_key, rsp_mon.waiting_for_key);
      bad += field_differs("sound_active", e.sound_active, rsp_mon.sound_active);
      bad += field_differs("pixel", e.pixel, rsp_mon.pixel);
      bad += field_differs("memory_byte", e.memory_byte, rsp_mon.memory_byte);
      bad += field_differs("unknown_opcode", e.unknown_opcode, rsp_mon.unknown_opcode);
      if (bad != 0) mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         rsp_expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) predict_rsp();
         if (rsp_mon.valid && rsp_mon.ready) compare_rsp();
      end
      outstanding = rsp_expected_q.size();
   end

endmodule

### tb/chip8_instruction_core_tb.sv
// top of the chip8 core testbench: clock, reset, request and response stimulus, verdict
`timescale 1ns / 1ps

module chip8_instruction_core_tb import c8core_pkg::*; ();

   logic              clock;
   logic              reset;
   int                mismatch_count;
   int                outstanding;
   logic [ADDR_W-1:0] model_pc;
   logic [ADDR_W-1:0] cur_pc;
   logic              quiet;
   logic              stall_request;
   logic              stall_done;
   int                hold_cnt;

   c8core_req_if req_chan ();
   c8core_rsp_if rsp_chan ();

   chip8_instruction_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   chip8_instruction_core_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .model_pc       (model_pc)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("chip8_instruction_core test failed");
      $finish;
   end

   // response side: random stall bursts plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      hold_cnt = 0;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            hold_cnt = 400;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_cnt = $urandom_range(0, 8);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // one request word; returns in the step where it was accepted, except that an exec first picks up the new pc
   task automatic send_word(input logic [2:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [7:0] data, input logic [3:0] key,
                            input logic pressed, input logic [7:0] rnd,
                            input logic [PIX_W-1:0] pix);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.address     <= addr;
      req_chan.data        <= data;
      req_chan.key_index   <= key;
      req_chan.key_pressed <= pressed;
      req_chan.random_byte <= rnd;
      req_chan.pixel_index <= pix;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_EXEC) begin
         // pick up the new pc before placing the next instruction
         req_chan.valid <= 1'b0;
         @(negedge clock);
         cur_pc = model_pc;
         @(posedge clock);
      end
   endtask

   task automatic run_op(input logic [15:0] op, input logic [7:0] rnd);
      send_word(CMD_LOAD, cur_pc, op[15:8], 4'h0, 1'b0, 8'h00, '0);
      send_word(CMD_LOAD, cur_pc + 12'd1, op[7:0], 4'h0, 1'b0, 8'h00, '0);
      send_word(CMD_EXEC, '0, 8'h00, 4'h0, 1'b0, rnd, '0);
   endtask

   function automatic logic [15:0] random_op();
      logic [15:0] op;
      logic [7:0]  fx_kk [11];
      logic [3:0]  alu_n [9];
      fx_kk = '{KK_LDDT, KK_LDK, KK_SETDT, KK_SETST, KK_ADDI, KK_FONT, KK_BCD,
                KK_STORE, KK_LOAD, KK_LDK, KK_ADDI};
      alu_n = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
      op = 16'($urandom);
      case (op[15:12])
         4'h0: begin
            case ($urandom_range(0, 5))
               0: op = OP_CLS;
               1, 2, 3: op = OP_RET;
               default: ;
            endcase
         end
         4'h5, 4'h9: if ($urandom_range(0, 4) != 0) op[3:0] = 4'h0;
         4'h8: if ($urandom_range(0, 7) != 0) op[3:0] = alu_n[$urandom_range(0, 8)];
         4'hD: if ($urandom_range(0, 2) != 0) op[3:0] = 4'($urandom_range(0, 5));
         4'hE: begin
            if ($urandom_range(0, 5) != 0) op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
         end
         4'hF: if ($urandom_range(0, 7) != 0) op[7:0] = fx_kk[$urandom_range(0, 10)];
         default: ;
      endcase
      return op;
   endfunction

   task automatic random_noise();
      send_word(3'($urandom), 12'($urandom), 8'($urandom), 4'($urandom),
                1'($urandom), 8'($urandom), 11'($urandom));
   endtask

   int n_items;

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      stall_request = 1'b0;
      cur_pc = PC_RESET;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_LOAD;
      req_chan.address     = '0;
      req_chan.data        = 8'h00;
      req_chan.key_index   = 4'h0;
      req_chan.key_pressed = 1'b0;
      req_chan.random_byte = 8'h00;
      req_chan.pixel_index = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      run_op(16'h60FF, 8'h00);
      run_op(16'h6101, 8'h00);
      run_op(16'h8014, 8'h00);            // carry out
      run_op(16'h8F15, 8'h00);            // subtract with VF as target, no borrow
      run_op(16'h801E, 8'h00);
      run_op(16'hF029, 8'h00);            // font glyph address
      run_op(16'hD01F, 8'h00);            // tall sprite of fifteen rows
      run_op(16'hD015, 8'h00);            // overlap sets collision
      send_word(CMD_PIXEL, '0, 8'h00, 4'h0, 1'b0, 8'h00, 11'h7FF);
      run_op(16'h0123, 8'h00);            // unknown 0nnn
      run_op(16'h5011, 8'h00);
      run_op(16'hF0FF, 8'h00);
      run_op(16'hCFAA, 8'hFF);
      run_op(16'hF00A, 8'h00);            // no key down, pc holds
      send_word(CMD_KEY, '0, 8'h00, 4'hF, 1'b1, 8'h00, '0);
      run_op(16'hE09E, 8'h00);
      run_op(16'hFF18, 8'h00);
      send_word(CMD_TICK, '0, 8'h00, 4'h0, 1'b0, 8'h00, '0);
      run_op(16'hA0FF, 8'h00);
      run_op(16'hF0B5, 8'h00);
      run_op(16'hF065, 8'h00);
      run_op(16'h2FFE, 8'h00);            // call to the top of memory
      run_op(16'h00EE, 8'h00);
      run_op(16'h1FFE, 8'h00);
      run_op(16'hB0FF, 8'h00);            // jump to nnn plus V0
      send_word(CMD_READ, 12'hFFF, 8'h00, 4'h0, 1'b0, 8'h00, '0);
      run_op(16'h00E0, 8'h00);
      send_word(3'd7, 12'hFFF, 8'hFF, 4'hF, 1'b1, 8'hFF, 11'h7FF);

      // random part
      n_items = 0;
      while (n_items < 450) begin
         if (n_items >= 200) stall_request = 1'b1;
         if (n_items >= 400) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1: begin
               random_noise();
               n_items += 1;
            end
            2: begin
               send_word(CMD_KEY, '0, 8'h00, 4'($urandom), 1'($urandom), 8'h00, '0);
               n_items += 1;
            end
            3: begin
               send_word($urandom_range(0, 1) ? CMD_TICK : CMD_PIXEL, '0, 8'h00, 4'h0,
                         1'b0, 8'h00, 11'($urandom));
               n_items += 1;
            end
            default: begin
               run_op(random_op(), 8'($urandom));
               n_items += 3;
            end
         endcase
      end
      req_chan.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("chip8_instruction_core test passed");
      end else begin
         $display("chip8_instruction_core test failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/c8core_pkg.sv
hw/rtl/c8core_req_if.sv
hw/rtl/c8core_rsp_if.sv
hw/rtl/c8core_mainmem.sv
hw/rtl/c8core_fbuf.sv
hw/rtl/c8core_vregs.sv
hw/rtl/c8core_seq.sv
hw/rtl/chip8_instruction_core.sv
tb/chip8_instruction_core_checker.sv
tb/chip8_instruction_core_tb.sv
